/* design/mpw_pkg.sv */
// ---------------------------------------------------------------------------
// mpw_pkg
// Shared types and constants for the MPEG program stream packet walker.
// ---------------------------------------------------------------------------
`default_nettype none

package mpw_pkg;

    localparam int WINDOW_BYTES     = 14;
    localparam int OFFSET_BITS_DEF  = 32;
    localparam int LEN_BITS         = 17;
    localparam int FILL_BITS        = $clog2(WINDOW_BYTES + 1);

    // Start codes (fourth header byte)
    localparam logic [7:0] SC_PACK      = 8'hBA;
    localparam logic [7:0] SC_SEQ_HDR   = 8'hB3;
    localparam logic [7:0] SC_EXT       = 8'hB5;
    localparam logic [7:0] SC_GOP       = 8'hB8;
    localparam logic [7:0] SC_END       = 8'hB9;
    localparam logic [7:0] SC_SYSTEM    = 8'hBB;
    localparam logic [7:0] SC_PRIV1     = 8'hBD;
    localparam logic [7:0] SC_PADDING   = 8'hBE;
    localparam logic [7:0] SC_PRIV2     = 8'hBF;
    localparam logic [7:0] SC_PES_FIRST = 8'hC0;
    localparam logic [7:0] SC_PES_LAST  = 8'hEF;

    // Extension identifiers (upper nibble of the fifth byte)
    localparam logic [3:0] EXT_SEQUENCE = 4'h1;
    localparam logic [3:0] EXT_DISPLAY  = 4'h2;
    localparam logic [3:0] EXT_PICTURE  = 4'h4;

    // Fixed packet lengths
    localparam logic [LEN_BITS-1:0] LEN_PACK2_BASE = LEN_BITS'(14);
    localparam logic [LEN_BITS-1:0] LEN_PACK1      = LEN_BITS'(12);
    localparam logic [LEN_BITS-1:0] LEN_SEQ        = LEN_BITS'(12);
    localparam logic [LEN_BITS-1:0] LEN_SEQ_MATRIX = LEN_BITS'(12 + 64);
    localparam logic [LEN_BITS-1:0] LEN_SEQ_EXT    = LEN_BITS'(10);
    localparam logic [LEN_BITS-1:0] LEN_DISP_EXT   = LEN_BITS'(9);
    localparam logic [LEN_BITS-1:0] LEN_DISP_COLOR = LEN_BITS'(12);
    localparam logic [LEN_BITS-1:0] LEN_PIC_EXT    = LEN_BITS'(9);
    localparam logic [LEN_BITS-1:0] LEN_PIC_EXT_LG = LEN_BITS'(11);
    localparam logic [LEN_BITS-1:0] LEN_GOP        = LEN_BITS'(8);
    localparam logic [LEN_BITS-1:0] LEN_END        = LEN_BITS'(4);
    localparam logic [LEN_BITS-1:0] LEN_PES_BIAS   = LEN_BITS'(6);

    typedef enum logic [1:0] {
        STAT_COLLECT = 2'd0,
        STAT_ACCEPT  = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_STOPPED = 2'd3
    } status_t;

    // Window, element 0 is the oldest byte
    typedef logic [WINDOW_BYTES-1:0][7:0] hdr_win_t;

    typedef struct packed {
        logic                stream_start;
        logic [7:0]          data_byte;
    } in_item_t;

    typedef struct packed {
        logic                ok;
        logic [LEN_BITS-1:0] len;
    } hdr_result_t;

endpackage

`default_nettype wire

/* design/mpw_in_reg.sv */
// ---------------------------------------------------------------------------
// mpw_in_reg
// Input register: captures one stream byte per transfer and holds it until
// the walker consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module mpw_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mpw_pkg::in_item_t s_item,
    input  wire logic              take,
    output logic                   item_valid,
    output mpw_pkg::in_item_t      item
);
    import mpw_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg, item_next;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        // load a new transfer
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            item_next  = s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

/* design/mpw_hdr_eval.sv */
// ---------------------------------------------------------------------------
// mpw_hdr_eval
// Header classifier: checks prefix, start code and marker bits of a full
// window and returns the packet length.
// ---------------------------------------------------------------------------
`default_nettype none

module mpw_hdr_eval (
    input  wire mpw_pkg::hdr_win_t win,
    output mpw_pkg::hdr_result_t   res
);
    import mpw_pkg::*;

    logic [7:0]          code;
    logic                prefix_ok;
    logic [3:0]          ext_id;
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] pes_len;

    assign code      = win[3];
    assign prefix_ok = (win[0] == 8'h00) && (win[1] == 8'h00) && (win[2] == 8'h01);
    assign ext_id    = win[4][7:4];
    assign pes_len   = LEN_BITS'({win[4], win[5]}) + LEN_PES_BIAS;

    always_comb begin
        len = '0;
        case (code)
            SC_PACK: begin
                if ((win[4] & 8'hC4) == 8'h44 && win[6][2] && win[8][2] &&
                    win[9][0] && (win[12][1:0] == 2'b11)) begin
                    len = LEN_PACK2_BASE + LEN_BITS'(win[13][2:0]);
                end else if ((win[4] & 8'hF1) == 8'h21 && win[6][0] && win[8][0] &&
                             win[9][7] && win[11][0]) begin
                    len = LEN_PACK1;
                end
            end
            SC_SEQ_HDR: begin
                if (win[10][5]) begin
                    len = (win[11][1:0] != 2'b00) ? LEN_SEQ_MATRIX : LEN_SEQ;
                end
            end
            SC_EXT: begin
                if (ext_id == EXT_SEQUENCE && win[7][0]) begin
                    len = LEN_SEQ_EXT;
                end else if (ext_id == EXT_DISPLAY && !win[4][0] && win[6][1]) begin
                    len = LEN_DISP_EXT;
                end else if (ext_id == EXT_DISPLAY && win[4][0] && win[9][1]) begin
                    len = LEN_DISP_COLOR;
                end else if (ext_id == EXT_PICTURE) begin
                    len = win[8][6] ? LEN_PIC_EXT_LG : LEN_PIC_EXT;
                end
            end
            SC_GOP: begin
                if (win[5][6]) begin
                    len = LEN_GOP;
                end
            end
            SC_END: begin
                len = LEN_END;
            end
            SC_SYSTEM, SC_PRIV1, SC_PADDING, SC_PRIV2: begin
                len = pes_len;
            end
            default: begin
                if (code >= SC_PES_FIRST && code <= SC_PES_LAST) begin
                    len = pes_len;
                end
            end
        endcase
        if (!prefix_ok) begin
            len = '0;
        end
    end

    assign res.len = len;
    assign res.ok  = (len != '0);

endmodule

`default_nettype wire

/* design/mpeg_ps_packet_walker.sv */
// Path: an input transfer passes through the input register, then the result
//   register, before its result shows on the m_ side.
// Throughput: one byte per cycle while m_ready is high; the walk state (window, countdown, offset)
//   is updated by a single registered pass per byte.
// Reset: aresetn is synchronous, active low; it clears both valid flags and
//   all walk state. No clearing pass is needed. s_stream_start also clears the fill, countdown, stop flag and offset.
// ---------------------------------------------------------------------------
// mpeg_ps_packet_walker
// Walks an MPEG program or elementary stream byte by byte, classifies each
// packet header at its expected offset and tracks the next packet start.
// ---------------------------------------------------------------------------
`default_nettype none

module mpeg_ps_packet_walker #(
    parameter int OFFSET_BITS = mpw_pkg::OFFSET_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // byte stream in
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_data_byte,
    input  wire logic         s_stream_start,
    // one result per byte out
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_status,
    output logic [16:0]       m_packet_length,
    output logic [7:0]        m_start_code,
    output logic [31:0]       m_next_packet_offset
);
    import mpw_pkg::*;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;

    assign s_item.stream_start = s_stream_start;
    assign s_item.data_byte    = s_data_byte;

    // Consume the held byte whenever the result register is free or drains.
    assign advance = item_valid && (!m_valid || m_ready);

    mpw_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // ------------------------------------------------------------------
    // Walk state
    // ------------------------------------------------------------------
    hdr_win_t               win_reg, win_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;
    logic [LEN_BITS-1:0]    btns_reg, btns_next;
    logic                   stop_reg, stop_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;

    // result register
    logic                   mval_reg, mval_next;
    status_t                stat_reg, stat_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [7:0]             code_reg, code_next;

    // state as seen by this byte (a stream start clears it first)
    logic [FILL_BITS-1:0]   eff_fill;
    logic [LEN_BITS-1:0]    eff_btns;
    logic                   eff_stop;
    logic [OFFSET_BITS-1:0] eff_off;
    logic                   was_full;
    hdr_win_t               win_shift;
    logic [LEN_BITS-1:0]    btns_dec;
    logic [FILL_BITS-1:0]   fill_upd;
    logic                   eval_now;
    hdr_result_t            hdr;
    logic [OFFSET_BITS:0]   off_sum;
    logic [OFFSET_BITS+31:0] off_ext;

    assign eff_fill = item.stream_start ? '0 : fill_reg;
    assign eff_btns = item.stream_start ? '0 : btns_reg;
    assign eff_stop = item.stream_start ? 1'b0 : stop_reg;
    assign eff_off  = item.stream_start ? '0 : off_reg;

    // Shift in at the young end unless stopped: once WINDOW_BYTES bytes have entered,
    // element 0 is the oldest, which is all the classifier ever sees.
    // Stale bytes left from an earlier stream are pushed out before use.
    assign win_shift = {item.data_byte, win_reg[WINDOW_BYTES-1:1]};
    assign was_full  = (eff_fill == FILL_BITS'(WINDOW_BYTES));
    assign fill_upd  = was_full ? eff_fill : eff_fill + FILL_BITS'(1);
    // count down toward the expected start only while the window slides
    assign btns_dec  = (was_full && eff_btns != '0) ? eff_btns - LEN_BITS'(1)
                                                    : eff_btns;
    assign eval_now  = (fill_upd == FILL_BITS'(WINDOW_BYTES)) && (btns_dec == '0);

    mpw_hdr_eval u_hdr_eval (
        .win (win_shift),
        .res (hdr)
    );

    // saturating offset advance
    assign off_sum = {1'b0, eff_off} + (OFFSET_BITS+1)'(hdr.len);
    assign off_ext = {32'b0, off_reg};

    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        btns_next = btns_reg;
        stop_next = stop_reg;
        off_next  = off_reg;
        mval_next = mval_reg;
        stat_next = stat_reg;
        len_next  = len_reg;
        code_next = code_reg;

        if (m_valid && m_ready) begin
            mval_next = 1'b0;
        end

        if (advance) begin
            mval_next = 1'b1;
            stat_next = STAT_COLLECT;
            len_next  = '0;
            code_next = '0;
            fill_next = eff_fill;
            btns_next = eff_btns;
            stop_next = eff_stop;
            off_next  = eff_off;

            if (eff_stop) begin
                // hold the frozen window, report stopped
                stat_next = STAT_STOPPED;
            end else begin
                win_next  = win_shift;
                fill_next = fill_upd;
                btns_next = btns_dec;
                if (eval_now) begin
                    code_next = win_shift[3];
                    if (!hdr.ok) begin
                        // drop out until the next stream start
                        stat_next = STAT_INVALID;
                        stop_next = 1'b1;
                    end else begin
                        stat_next = STAT_ACCEPT;
                        len_next  = hdr.len;
                        btns_next = hdr.len;
                        off_next  = off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            btns_reg <= '0;
            stop_reg <= 1'b0;
            off_reg  <= '0;
            mval_reg <= 1'b0;
            win_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            btns_reg <= btns_next;
            stop_reg <= stop_next;
            off_reg  <= off_next;
            mval_reg <= mval_next;
            win_reg  <= win_next;
        end
        stat_reg <= stat_next;
        len_reg  <= len_next;
        code_reg <= code_next;
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    assign m_valid              = mval_reg;
    assign m_status             = stat_reg;
    assign m_packet_length      = len_reg;
    assign m_start_code         = code_reg;
    assign m_next_packet_offset = off_ext[31:0];

endmodule

`default_nettype wire

/* design/mpw_checker.sv */
// ---------------------------------------------------------------------------
// mpw_checker
// Port-level checks for the MPEG program stream packet walker.
// ---------------------------------------------------------------------------
`default_nettype none

module mpw_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [7:0]  s_data_byte,
    input wire logic        s_stream_start,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [16:0] m_packet_length,
    input wire logic [7:0]  m_start_code,
    input wire logic [31:0] m_next_packet_offset
);
    import mpw_pkg::*;

    // a stalled result transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_packet_length) && $stable(m_next_packet_offset))
        else $error("result changed while stalled");

    // only an accepted header carries a length
    a_len_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_ACCEPT |-> m_packet_length == '0)
        else $error("length reported without an accepted header");

    a_accept_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_ACCEPT |-> m_packet_length >= 17'(4))
        else $error("accepted header with impossible length");

    // start code appears only when a header was evaluated
    a_code_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_COLLECT || m_status == STAT_STOPPED)
        |-> m_start_code == 8'h00)
        else $error("start code shown without header evaluation");

    // a result appears only after its byte has passed the input register and the result register
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without an input transfer");

endmodule

bind mpeg_ps_packet_walker mpw_checker u_mpw_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .s_data_byte          (s_data_byte),
    .s_stream_start       (s_stream_start),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_status             (m_status),
    .m_packet_length      (m_packet_length),
    .m_start_code         (m_start_code),
    .m_next_packet_offset (m_next_packet_offset)
);

`default_nettype wire
